// ----- rtl/e2rm_pkg.sv -----
// Package with the types, constants and tables of the Euler-angle to rotation-matrix block.
package e2rm_pkg;

    localparam int ANGLE_WIDTH  = 16;
    localparam int ENTRY_WIDTH  = 16;
    localparam int CORDIC_STEPS = 16;

    // CORDIC datapath width: Q2.30 plus growth headroom.
    localparam int CW = 34;

    localparam logic signed [CW-1:0] Q30_PI      = CW'(64'sh0C90FDAA2);
    localparam logic signed [CW-1:0] Q30_HALF_PI = CW'(64'sh06487ED51);
    localparam logic signed [CW-1:0] Q30_GAIN    = CW'(64'sh026DD3B6A);

    typedef struct packed {
        logic signed [ANGLE_WIDTH-1:0] heading_angle;
        logic signed [ANGLE_WIDTH-1:0] pitch_angle;
        logic signed [ANGLE_WIDTH-1:0] bank_angle;
    } t_in_item;

    typedef struct packed {
        logic signed [ENTRY_WIDTH-1:0] row1_col1;
        logic signed [ENTRY_WIDTH-1:0] row1_col2;
        logic signed [ENTRY_WIDTH-1:0] row1_col3;
        logic signed [ENTRY_WIDTH-1:0] row2_col1;
        logic signed [ENTRY_WIDTH-1:0] row2_col2;
        logic signed [ENTRY_WIDTH-1:0] row2_col3;
        logic signed [ENTRY_WIDTH-1:0] row3_col1;
        logic signed [ENTRY_WIDTH-1:0] row3_col2;
        logic signed [ENTRY_WIDTH-1:0] row3_col3;
    } t_out_item;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
        logic                 flip;
    } t_cordic;

    function automatic logic signed [CW-1:0] atan_q30(input logic [4:0] i);
        logic signed [CW-1:0] v;
        unique case (i)
            5'd0:  v = CW'(32'h3243F6A8);
            5'd1:  v = CW'(32'h1DAC6705);
            5'd2:  v = CW'(32'h0FADBAFC);
            5'd3:  v = CW'(32'h07F56EA6);
            5'd4:  v = CW'(32'h03FEAB76);
            5'd5:  v = CW'(32'h01FFD55B);
            5'd6:  v = CW'(32'h00FFFAAA);
            5'd7:  v = CW'(32'h007FFF55);
            5'd8:  v = CW'(32'h003FFFEA);
            5'd9:  v = CW'(32'h001FFFFD);
            5'd10: v = CW'(32'h000FFFFF);
            5'd11: v = CW'(32'h0007FFFF);
            5'd12: v = CW'(32'h0003FFFF);
            5'd13: v = CW'(32'h0001FFFF);
            5'd14: v = CW'(32'h0000FFFF);
            5'd15: v = CW'(32'h00007FFF);
            5'd16: v = CW'(32'h00003FFF);
            5'd17: v = CW'(32'h00001FFF);
            5'd18: v = CW'(32'h00000FFF);
            5'd19: v = CW'(32'h000007FF);
            5'd20: v = CW'(32'h000003FF);
            5'd21: v = CW'(32'h000001FF);
            5'd22: v = CW'(32'h000000FF);
            5'd23: v = CW'(32'h0000007F);
            5'd24: v = CW'(32'h0000003F);
            5'd25: v = CW'(32'h0000001F);
            5'd26: v = CW'(32'h0000000F);
            5'd27: v = CW'(32'h00000008);
            5'd28: v = CW'(32'h00000004);
            5'd29: v = CW'(32'h00000002);
            5'd30: v = CW'(32'h00000001);
            default: v = '0;
        endcase
        return v;
    endfunction

    // Q30 product floored back to Q30; operands lie within plus or minus one.
    function automatic logic signed [CW-1:0] mul_q30(input logic signed [CW-1:0] a,
                                                     input logic signed [CW-1:0] b);
        logic signed [2*CW-1:0] p;
        p = a * b;
        return p[CW+29:30];
    endfunction

    function automatic logic signed [ENTRY_WIDTH-1:0] to_entry(input logic signed [CW+1:0] v);
        localparam int S = 32 - ENTRY_WIDTH;
        localparam logic signed [CW+1:0] ONE = (CW+2)'(1) <<< (ENTRY_WIDTH - 2);
        logic signed [CW+1:0] r;
        r = (v + ((CW+2)'(1) <<< (S - 1))) >>> S;
        if (r > ONE) r = ONE;
        if (r < -ONE) r = -ONE;
        return r[ENTRY_WIDTH-1:0];
    endfunction

endpackage

// ----- rtl/euler_to_rotation_matrix.sv -----
// Top level: pipelined heading-pitch-bank angles to world-to-object rotation matrix.
//
// Takes one orientation per cycle while o_stall is low and returns the nine matrix entries
// in Q1.14 through registered stages: one reduction stage, one stage per CORDIC iteration
// (three CORDIC units run side by side), two product stages, one sum stage and one output
// stage. Every stage advances together when the output is not stalled, so the block
// sustains one item per clock.
module euler_to_rotation_matrix
    import e2rm_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_item  i_data,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_item o_data
);

    localparam int NS = CORDIC_STEPS;

    // Advance when the output register is empty or being taken.
    logic adv;
    assign adv     = !o_valid || !i_stall;
    assign o_stall = !adv;

    // Stage 0: angle scaling and quadrant reduction.
    t_cordic r_c [3][NS+1];
    logic    r_v [NS+1];
    logic signed [ANGLE_WIDTH-1:0] ang [3];
    assign ang[0] = i_data.heading_angle;
    assign ang[1] = i_data.pitch_angle;
    assign ang[2] = i_data.bank_angle;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= NS; s++) r_v[s] <= 1'b0;
        end else if (adv) begin
            r_v[0] <= i_valid;
            for (int s = 1; s <= NS; s++) r_v[s] <= r_v[s-1];
        end
    end

    for (genvar a = 0; a < 3; a++) begin : g_ang
        logic signed [CW-1:0] th;
        t_cordic n_c0;
        assign th = CW'(ang[a]) <<< (30 - (ANGLE_WIDTH - 3));
        always_comb begin
            n_c0.x = Q30_GAIN;
            n_c0.y = '0;
            n_c0.z = th;
            n_c0.flip = 1'b0;
            if (th > Q30_HALF_PI) begin
                n_c0.z = th - Q30_PI;
                n_c0.flip = 1'b1;
            end else if (th < -Q30_HALF_PI) begin
                n_c0.z = th + Q30_PI;
                n_c0.flip = 1'b1;
            end
        end
        always_ff @(posedge i_clk) begin
            if (adv) r_c[a][0] <= n_c0;
        end

        for (genvar s = 0; s < NS; s++) begin : g_step
            t_cordic n_c;
            t_cordic p;
            assign p = r_c[a][s];
            always_comb begin
                n_c.flip = p.flip;
                if (!p.z[CW-1]) begin
                    n_c.x = p.x - (p.y >>> s);
                    n_c.y = p.y + (p.x >>> s);
                    n_c.z = p.z - atan_q30(5'(s));
                end else begin
                    n_c.x = p.x + (p.y >>> s);
                    n_c.y = p.y - (p.x >>> s);
                    n_c.z = p.z + atan_q30(5'(s));
                end
            end
            always_ff @(posedge i_clk) begin
                if (adv) r_c[a][s+1] <= n_c;
            end
        end
    end

    logic signed [CW-1:0] sn [3];
    logic signed [CW-1:0] cs [3];
    for (genvar a = 0; a < 3; a++) begin : g_sc
        assign sn[a] = r_c[a][NS].flip ? -r_c[a][NS].y : r_c[a][NS].y;
        assign cs[a] = r_c[a][NS].flip ? -r_c[a][NS].x : r_c[a][NS].x;
    end

    // Product stage 1: pair products and pass-through of the single factors.
    logic                 r_v1, r_v2, r_v3;
    logic signed [CW-1:0] r_chcb, r_shsp, r_chsb, r_shcp, r_sbcp, r_cbcp, r_sp;
    logic signed [CW-1:0] r_shcb, r_chsp, r_sbsh, r_chcp, r_sb, r_cb;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v1 <= 1'b0;
        else if (adv) r_v1 <= r_v[NS];
        if (adv) begin
            r_chcb <= mul_q30(cs[0], cs[2]);
            r_shsp <= mul_q30(sn[0], sn[1]);
            r_chsb <= mul_q30(cs[0], sn[2]);
            r_shcp <= mul_q30(sn[0], cs[1]);
            r_sbcp <= mul_q30(sn[2], cs[1]);
            r_cbcp <= mul_q30(cs[2], cs[1]);
            r_shcb <= mul_q30(sn[0], cs[2]);
            r_chsp <= mul_q30(cs[0], sn[1]);
            r_sbsh <= mul_q30(sn[2], sn[0]);
            r_chcp <= mul_q30(cs[0], cs[1]);
            r_sp   <= sn[1];
            r_sb   <= sn[2];
            r_cb   <= cs[2];
        end
    end

    // Product stage 2: triple products and pass-through of the other terms.
    logic signed [CW-1:0] r2_a, r2_b, r2_c, r2_d;
    logic signed [CW-1:0] r2_chcb, r2_chsb, r2_shcp, r2_sbcp, r2_cbcp, r2_sp;
    logic signed [CW-1:0] r2_shcb, r2_sbsh, r2_chcp;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v2 <= 1'b0;
        else if (adv) r_v2 <= r_v1;
        if (adv) begin
            r2_a <= mul_q30(r_shsp, r_sb);
            r2_b <= mul_q30(r_shsp, r_cb);
            r2_c <= mul_q30(r_chsp, r_sb);
            r2_d <= mul_q30(r_chsp, r_cb);
            r2_chcb <= r_chcb; r2_chsb <= r_chsb; r2_shcp <= r_shcp;
            r2_sbcp <= r_sbcp; r2_cbcp <= r_cbcp; r2_sp <= r_sp;
            r2_shcb <= r_shcb; r2_sbsh <= r_sbsh; r2_chcp <= r_chcp;
        end
    end

    // Sum, rounding and saturation stage.
    t_out_item r_sum;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v3 <= 1'b0;
        else if (adv) r_v3 <= r_v2;
        if (adv) begin
            r_sum.row1_col1 <= to_entry((CW+2)'(r2_chcb) + (CW+2)'(r2_a));
            r_sum.row1_col2 <= to_entry((CW+2)'(r2_b) - (CW+2)'(r2_chsb));
            r_sum.row1_col3 <= to_entry((CW+2)'(r2_shcp));
            r_sum.row2_col1 <= to_entry((CW+2)'(r2_sbcp));
            r_sum.row2_col2 <= to_entry((CW+2)'(r2_cbcp));
            r_sum.row2_col3 <= to_entry(-(CW+2)'(r2_sp));
            r_sum.row3_col1 <= to_entry((CW+2)'(r2_c) - (CW+2)'(r2_shcb));
            r_sum.row3_col2 <= to_entry((CW+2)'(r2_sbsh) + (CW+2)'(r2_d));
            r_sum.row3_col3 <= to_entry((CW+2)'(r2_chcp));
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) o_valid <= 1'b0;
        else if (adv) o_valid <= r_v3;
        if (adv) o_data <= r_sum;
    end

endmodule

// ----- bench/tb_euler_to_rotation_matrix.sv -----
// Self-checking testbench for the Euler-angle to rotation-matrix block.
module tb_euler_to_rotation_matrix;
    import e2rm_pkg::*;

    localparam int LATENCY = CORDIC_STEPS + 5;
    localparam int MAX_CYCLES = 1000000;
    localparam int N_RANDOM = 1800;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    t_in_item  in_data;
    logic      out_valid;
    logic      out_stall;
    t_out_item out_data;

    euler_to_rotation_matrix dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(in_valid), .o_stall(in_stall), .i_data(in_data),
        .o_valid(out_valid), .i_stall(out_stall), .o_data(out_data)
    );

    t_out_item matrix_q[$];
    int        n_mismatch;
    int        cycle_cnt;
    bit        hold_off_req;
    bit        hold_off_done;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic longint floor_sh(longint v, int s);
        return v >>> s;
    endfunction

    function automatic void sin_cos(logic signed [ANGLE_WIDTH-1:0] a,
                                    output longint s, output longint c);
        longint x, y, z, dx, dy;
        bit flip;
        longint atan_tab[16] = '{
            64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
            64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
            64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
            64'h00007FFF};
        x = 64'h26DD3B6A;
        y = 0;
        z = longint'(a) * (longint'(1) << (30 - (ANGLE_WIDTH - 3)));
        flip = 1'b0;
        if (z > 64'sh6487ED51) begin
            z -= 64'shC90FDAA2;
            flip = 1'b1;
        end else if (z < -64'sh6487ED51) begin
            z += 64'shC90FDAA2;
            flip = 1'b1;
        end
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            dx = floor_sh(y, i);
            dy = floor_sh(x, i);
            if (z >= 0) begin
                x -= dx; y += dy; z -= atan_tab[i];
            end else begin
                x += dx; y -= dy; z += atan_tab[i];
            end
        end
        s = flip ? -y : y;
        c = flip ? -x : x;
    endfunction

    function automatic longint qmul(longint a, longint b);
        return floor_sh(a * b, 30);
    endfunction

    function automatic logic signed [ENTRY_WIDTH-1:0] round_entry(longint v);
        longint r, one;
        one = longint'(1) << (ENTRY_WIDTH - 2);
        r = floor_sh(v + (longint'(1) << (32 - ENTRY_WIDTH - 1)), 32 - ENTRY_WIDTH);
        if (r > one) r = one;
        if (r < -one) r = -one;
        return r[ENTRY_WIDTH-1:0];
    endfunction

    function automatic t_out_item rotation_of(t_in_item a);
        longint sh, ch, sp, cp, sb, cb;
        t_out_item m;
        sin_cos(a.heading_angle, sh, ch);
        sin_cos(a.pitch_angle, sp, cp);
        sin_cos(a.bank_angle, sb, cb);
        m.row1_col1 = round_entry(qmul(ch, cb) + qmul(qmul(sh, sp), sb));
        m.row1_col2 = round_entry(-qmul(ch, sb) + qmul(qmul(sh, sp), cb));
        m.row1_col3 = round_entry(qmul(sh, cp));
        m.row2_col1 = round_entry(qmul(sb, cp));
        m.row2_col2 = round_entry(qmul(cb, cp));
        m.row2_col3 = round_entry(-sp);
        m.row3_col1 = round_entry(-qmul(sh, cb) + qmul(qmul(ch, sp), sb));
        m.row3_col2 = round_entry(qmul(sb, sh) + qmul(qmul(ch, sp), cb));
        m.row3_col3 = round_entry(qmul(ch, cp));
        return m;
    endfunction

    function automatic int gap_len();
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
        if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
        return 0;
    endfunction

    // Directed rows: zero angles give the identity; the others go to the predictor.
    typedef struct {
        t_in_item  angles;
        bit        fixed;
        t_out_item matrix;
    } t_row;

    localparam logic signed [15:0] P1 = 16'sh4000;
    localparam logic signed [15:0] ZR = 16'sh0000;

    t_row rows[] = '{
        '{'{16'sh0000, 16'sh0000, 16'sh0000}, 1'b1, '{P1, ZR, ZR, ZR, P1, ZR, ZR, ZR, P1}},
        '{'{16'sh7FFF, 16'sh7FFF, 16'sh7FFF}, 1'b0, '0},
        '{'{-16'sh8000, -16'sh8000, -16'sh8000}, 1'b0, '0},
        '{'{16'sh7FFF, -16'sh8000, 16'sh0000}, 1'b0, '0},
        '{'{16'sh3244, 16'sh0000, 16'sh0000}, 1'b0, '0},
        '{'{16'sh0000, 16'sh3244, 16'sh0000}, 1'b0, '0},
        '{'{16'sh0000, -16'sh3244, 16'sh0000}, 1'b0, '0},
        '{'{16'sh0000, 16'sh0000, 16'sh3243}, 1'b0, '0},
        '{'{16'sh6488, 16'sh6487, -16'sh6488}, 1'b0, '0},
        '{'{16'sh3243, 16'sh3245, -16'sh3245}, 1'b0, '0},
        '{'{16'sh0001, -16'sh0001, 16'sh0001}, 1'b0, '0},
        '{'{16'shFFFF, 16'sh5555, 16'shAAAA}, 1'b0, '0},
        '{'{16'sh1921, 16'sh1921, 16'sh1921}, 1'b0, '0},
        '{'{16'sh4B66, -16'sh4B66, 16'sh7000}, 1'b0, '0}
    };

    // Valid stays high after an item so that the next one can follow without a gap.
    task automatic send_item(t_in_item a, t_out_item m);
        in_valid <= 1'b1;
        in_data  <= a;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        matrix_q.push_back(m);
    endtask

    task automatic pause_cycles(int n);
        if (n > 0) begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    function automatic t_in_item random_angles();
        t_in_item a;
        a = t_in_item'((3*ANGLE_WIDTH)'({$urandom, $urandom}));
        // Bias some items toward the reduction boundaries at plus or minus pi/2.
        if ($urandom_range(0, 3) == 0)
            a.pitch_angle = ($urandom_range(0, 1) ? 16'sh3244 : -16'sh3244)
                            + 16'($signed($urandom_range(0, 6)) - 3);
        return a;
    endfunction

    // Result checker.
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            if (matrix_q.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10) $display("unexpected item %h", out_data);
            end else begin
                t_out_item e;
                e = matrix_q.pop_front();
                if (out_data !== e) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("mismatch: expected %h actual %h", e, out_data);
                end
            end
        end
    end

    // Receiver stall, with one long hold-off on request.
    initial begin
        int g;
        out_stall <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_off_req && !hold_off_done) begin
                out_stall <= 1'b1;
                repeat (3 * LATENCY + 40) @(posedge clk);
                hold_off_done = 1'b1;
                out_stall <= 1'b0;
            end else begin
                g = gap_len();
                if (g > 0) begin
                    out_stall <= 1'b1;
                    repeat (g) @(posedge clk);
                    out_stall <= 1'b0;
                end
            end
        end
    end

    // Cycle limit.
    initial begin
        cycle_cnt = 0;
        forever begin
            @(posedge clk);
            cycle_cnt++;
            if (cycle_cnt > MAX_CYCLES) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial begin
        t_in_item a;
        n_mismatch    = 0;
        hold_off_req  = 1'b0;
        hold_off_done = 1'b0;
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        in_data  <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i]) begin
            send_item(rows[i].angles,
                      rows[i].fixed ? rows[i].matrix : rotation_of(rows[i].angles));
            pause_cycles(gap_len());
        end
        // Sender pauses until every result has drained.
        in_valid <= 1'b0;
        while (matrix_q.size() != 0) @(posedge clk);

        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == 200) hold_off_req = 1'b1;
            if (n == 900) begin
                in_valid <= 1'b0;
                while (matrix_q.size() != 0) @(posedge clk);
            end
            a = random_angles();
            send_item(a, rotation_of(a));
            // Back-to-back runs keep the pipeline full for stretches.
            if (!(n >= 200 && n < 400)) pause_cycles(gap_len());
        end

        in_valid <= 1'b0;
        while (matrix_q.size() != 0) @(posedge clk);
        pause_cycles(LATENCY + 5);
        if (n_mismatch == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ----- euler_to_rotation_matrix.f -----
rtl/e2rm_pkg.sv
rtl/euler_to_rotation_matrix.sv
bench/tb_euler_to_rotation_matrix.sv
